[design/ssi_aar_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_aar_pkg
// Shared types and constants of the SSI absolute angle reader.
// ----------------------------------------------------------------------------
package ssi_aar_pkg;

  // configuration register widths
  localparam int unsigned OffsetW = 12;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned PeriodW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  // remaining-bit counter width, holds up to 15
  localparam int unsigned BitsW   = 4;

  // input transaction: data_line in bit 0, padded to a byte
  localparam int unsigned InTdataW = 8;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_DELAY  = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_idx_e;

  // read sequencer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_CSWAIT  = 5'b00010,
    PH_CLKLOW  = 5'b00100,
    PH_CLKHIGH = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  // pin levels and update flag after one tick
  typedef struct packed {
    logic cs;
    logic sclk;
    logic valid;
  } pins_t;

endpackage

[design/ssi_absolute_angle_reader.sv]
// ----------------------------------------------------------------------------
// ssi_absolute_angle_reader
// Bit-banged SSI read of an absolute angle encoder, one timebase tick per
// input transaction, one result transaction per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one timebase tick carrying the sampled encoder
// data pin; each produces exactly one output transaction with the chip select
// and clock pin levels, the update flag, the offset-corrected angle and the
// last raw reading. The block takes one transaction every clock cycle
// while the result stream is not stalled; a transaction passes through the
// input register and then the result register, and the sequencer advances
// one tick as it moves from the first to the second. A stalled result holds
// the input register, which then holds the input side.
// Configuration registers are written through the cfg port; the offset
// applies to every result computed after the write.
// ----------------------------------------------------------------------------
module ssi_absolute_angle_reader #(
  parameter int unsigned ANGLE_BITS = 12,
  localparam int unsigned OutFieldsW = 2 * ANGLE_BITS + 4,
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [ssi_aar_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ssi_aar_pkg::CfgW-1:0]          cfg_wdata_i,
  // tick stream in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ssi_aar_pkg::InTdataW-1:0]      s_axis_tdata,  // data_line
  // result stream out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // sel_n, serial_clock, angle_valid, angle, raw_count
  output logic [OutTdataW-1:0]                  m_axis_tdata
);

  logic signed [ssi_aar_pkg::OffsetW-1:0] offset_q;
  logic [ssi_aar_pkg::DelayW-1:0]         delay_q;
  logic [ssi_aar_pkg::PeriodW-1:0]        period_q;

  logic                                   in_valid_q;
  logic                                   data_q;
  logic                                   out_valid_q;
  logic [OutFieldsW-1:0]                  out_q;
  logic                                   advance;

  ssi_aar_pkg::pins_t                     pins;
  logic [ANGLE_BITS-1:0]                  raw;
  logic signed [ANGLE_BITS:0]             angle;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      delay_q  <= ssi_aar_pkg::DelayW'(25);
      period_q <= ssi_aar_pkg::PeriodW'(500000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssi_aar_pkg::CFG_OFFSET: offset_q <= cfg_wdata_i[ssi_aar_pkg::OffsetW-1:0];
        ssi_aar_pkg::CFG_DELAY:  delay_q  <= cfg_wdata_i[ssi_aar_pkg::DelayW-1:0];
        ssi_aar_pkg::CFG_PERIOD: period_q <= cfg_wdata_i[ssi_aar_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the tick moves on when the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      data_q <= s_axis_tdata[0];
    end
  end

  // read sequencer
  ssi_aar_ctrl #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .data_i        (data_q),
    .bit_delay_i   (delay_q),
    .poll_period_i (period_q),
    .pins_o        (pins),
    .raw_o         (raw)
  );

  // angle conversion
  ssi_aar_angle #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .raw_i    (raw),
    .offset_i (offset_q),
    .angle_o  (angle)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= {raw, angle, pins.valid, pins.sclk, pins.cs};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_q);

endmodule

[design/ssi_aar_ctrl.sv]
// ----------------------------------------------------------------------------
// ssi_aar_ctrl
// Read sequencer: poll timer, chip select and clock pin control, bit delay
// counter and MSB-first shift register. Advances one tick per step.
// ----------------------------------------------------------------------------
module ssi_aar_ctrl #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             data_i,
  input  logic [ssi_aar_pkg::DelayW-1:0]   bit_delay_i,
  input  logic [ssi_aar_pkg::PeriodW-1:0]  poll_period_i,
  output ssi_aar_pkg::pins_t               pins_o,
  output logic [ANGLE_BITS-1:0]            raw_o
);

  localparam logic [ANGLE_BITS-1:0] RawReset = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic [ssi_aar_pkg::BitsW-1:0] BitsInit =
    ssi_aar_pkg::BitsW'(ANGLE_BITS - 1);

  ssi_aar_pkg::phase_e                 phase_q, phase_d;
  logic [ssi_aar_pkg::BitsW-1:0]       bits_q, bits_d;
  logic [ssi_aar_pkg::DelayW-1:0]      delay_q, delay_d;
  logic [ssi_aar_pkg::PeriodW-1:0]     period_q, period_d;
  logic [ANGLE_BITS-1:0]               shift_q, shift_d;
  logic [ANGLE_BITS-1:0]               raw_q, raw_d;
  logic [ssi_aar_pkg::PeriodW:0]       period_inc;
  logic                                start;
  logic                                delay_end;
  logic                                valid;

  // poll timer, restarts when it reaches the period
  always_comb begin
    period_inc = {1'b0, period_q} + 1'b1;
    start      = (period_q == '0);
    if (period_inc >= {1'b0, poll_period_i}) begin
      period_d = '0;
    end else begin
      period_d = period_inc[ssi_aar_pkg::PeriodW-1:0];
    end
  end

  // sequencer next state
  always_comb begin
    phase_d   = phase_q;
    bits_d    = bits_q;
    delay_d   = delay_q;
    shift_d   = shift_q;
    raw_d     = raw_q;
    valid     = 1'b0;
    delay_end = (delay_q <= ssi_aar_pkg::DelayW'(1));
    unique case (phase_q)
      ssi_aar_pkg::PH_CSWAIT: begin
        if (delay_end) begin
          phase_d = ssi_aar_pkg::PH_CLKLOW;
        end else begin
          delay_d = delay_q - 1'b1;
        end
      end
      ssi_aar_pkg::PH_CLKLOW: begin
        phase_d = ssi_aar_pkg::PH_CLKHIGH;
        delay_d = bit_delay_i;
      end
      ssi_aar_pkg::PH_CLKHIGH: begin
        if (delay_end) begin
          shift_d = {shift_q[ANGLE_BITS-2:0], data_i};
          if (bits_q == '0) begin
            phase_d = ssi_aar_pkg::PH_DONE;
          end else begin
            bits_d  = bits_q - 1'b1;
            phase_d = ssi_aar_pkg::PH_CLKLOW;
          end
        end else begin
          delay_d = delay_q - 1'b1;
        end
      end
      ssi_aar_pkg::PH_DONE: begin
        raw_d   = shift_q;
        valid   = 1'b1;
        phase_d = ssi_aar_pkg::PH_IDLE;
      end
      default: begin
        phase_d = ssi_aar_pkg::PH_IDLE;
        if (start) begin
          phase_d = ssi_aar_pkg::PH_CSWAIT;
          delay_d = bit_delay_i;
          bits_d  = BitsInit;
          shift_d = '0;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ssi_aar_pkg::PH_IDLE;
      bits_q   <= '0;
      delay_q  <= '0;
      period_q <= '0;
      shift_q  <= '0;
      raw_q    <= RawReset;
    end else if (step_i) begin
      phase_q  <= phase_d;
      bits_q   <= bits_d;
      delay_q  <= delay_d;
      period_q <= period_d;
      shift_q  <= shift_d;
      raw_q    <= raw_d;
    end
  end

  // pin levels after this tick
  assign pins_o.cs    = (phase_d == ssi_aar_pkg::PH_IDLE);
  assign pins_o.sclk  = (phase_d != ssi_aar_pkg::PH_CLKLOW);
  assign pins_o.valid = valid;
  assign raw_o        = raw_d;

  // a low clock tick is always followed by the high hold
  a_low_then_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == ssi_aar_pkg::PH_CLKLOW |=> phase_q == ssi_aar_pkg::PH_CLKHIGH)
    else $error("clock low phase not followed by high phase");

  // the angle only updates when a read finishes
  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid |-> step_i || phase_q == ssi_aar_pkg::PH_DONE)
    else $error("angle update outside of read completion");

  // raw reading only changes on a completed read
  a_raw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && phase_q == ssi_aar_pkg::PH_DONE) |=> $stable(raw_q))
    else $error("raw reading changed without a completed read");

  // bit counter stays within the word
  a_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BitsInit)
    else $error("bit counter out of range");

endmodule

[design/ssi_aar_angle.sv]
// ----------------------------------------------------------------------------
// ssi_aar_angle
// Converts the raw reading to a signed angle, subtracts the zero offset and
// wraps the result once into the half-turn range.
// ----------------------------------------------------------------------------
module ssi_aar_angle #(
  parameter int unsigned ANGLE_BITS = 12
) (
  input  logic [ANGLE_BITS-1:0]                   raw_i,
  input  logic signed [ssi_aar_pkg::OffsetW-1:0]  offset_i,
  output logic signed [ANGLE_BITS:0]              angle_o
);

  localparam int unsigned BaseW = (ANGLE_BITS > ssi_aar_pkg::OffsetW) ?
                                  ANGLE_BITS : ssi_aar_pkg::OffsetW;
  localparam int unsigned WorkW = BaseW + 2;
  localparam logic signed [WorkW-1:0] Half = WorkW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [WorkW-1:0] Full = WorkW'(1) <<< ANGLE_BITS;

  logic signed [ANGLE_BITS-1:0] held;
  logic signed [WorkW-1:0]      adj;
  logic signed [WorkW-1:0]      wrapped;

  // raw minus half scale is the raw word with its top bit flipped
  assign held = {~raw_i[ANGLE_BITS-1], raw_i[ANGLE_BITS-2:0]};

  // offset correction and single wrap
  always_comb begin
    adj     = WorkW'(held) - WorkW'(offset_i);
    wrapped = adj;
    if (adj < -Half) begin
      wrapped = adj + Full;
    end else if (adj > Half) begin
      wrapped = adj - Full;
    end
  end

  assign angle_o = wrapped[ANGLE_BITS:0];

endmodule

[dv/tb_ssi_absolute_angle_reader.sv]
// ----------------------------------------------------------------------------
// tb_ssi_absolute_angle_reader
// Self-checking bench for the SSI absolute angle reader. Every tick sent in
// is run through a tick-level model of the read sequencer, and the chip
// select, serial clock, update flag, angle and raw reading it predicts are
// compared against the result stream. Settings change only between phases,
// once the result stream has drained, and both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ssi_absolute_angle_reader;

  localparam int ANGLE_BITS  = 12;
  localparam int HALF_RANGE  = 1 << (ANGLE_BITS - 1);
  localparam int FULL_RANGE  = 1 << ANGLE_BITS;
  localparam int OUT_W       = 32;
  localparam int TICK_TARGET = 1150;
  localparam int CYCLE_LIMIT = 600000;

  // data line pattern of queued ticks
  localparam int LINE_RANDOM = 0;
  localparam int LINE_ONES   = 1;
  localparam int LINE_ZEROS  = 2;

  // one result transaction, chip select in the lowest bit
  typedef struct packed {
    logic [ANGLE_BITS-1:0] raw;
    logic [ANGLE_BITS:0]   angle;
    logic                  valid;
    logic                  sclk;
    logic                  cs;
  } reading_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic [ssi_aar_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [ssi_aar_pkg::CfgW-1:0]     cfg_wdata_i   = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [ssi_aar_pkg::InTdataW-1:0] s_axis_tdata  = '0;   // data_line
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // sel_n, serial_clock, angle_valid, angle, raw_count
  logic [OUT_W-1:0]                 m_axis_tdata;

  ssi_absolute_angle_reader #(
    .ANGLE_BITS(ANGLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // ticks waiting to be sent and readings waiting to come back
  logic [ssi_aar_pkg::InTdataW-1:0] tick_q[$];
  reading_t                         reading_q[$];

  int unsigned ticks_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned feed_wait    = 0;
  int unsigned sink_wait    = 0;
  int unsigned feed_gap_max = 16;
  int unsigned sink_gap_max = 16;

  // register mirror, reset values
  logic signed [ssi_aar_pkg::OffsetW-1:0] zero_offset = '0;
  logic [ssi_aar_pkg::DelayW-1:0]         bit_delay   = 16'd25;
  logic [ssi_aar_pkg::PeriodW-1:0]        poll_period = 24'd500000;

  // sequencer mirror, reset values
  ssi_aar_pkg::phase_e              seq_phase      = ssi_aar_pkg::PH_IDLE;
  logic [ssi_aar_pkg::BitsW-1:0]    bits_to_go     = '0;
  logic [ssi_aar_pkg::DelayW-1:0]   wait_ticks     = '0;
  logic [ssi_aar_pkg::PeriodW-1:0]  tick_in_period = '0;
  logic [ANGLE_BITS-1:0]            shift_reg      = '0;
  int                               held_angle     = 0;

  // advance the sequencer mirror by one tick and return the pins and values
  function automatic reading_t advance_tick(input logic data_bit);
    reading_t      r;
    logic [24:0]   nxt;
    logic          start_now;
    logic          done_now;
    int            adj;
    int            raw_sum;
    start_now = (tick_in_period == '0);
    done_now  = 1'b0;
    nxt = {1'b0, tick_in_period} + 25'd1;
    if (nxt >= {1'b0, poll_period}) nxt = '0;
    tick_in_period = nxt[ssi_aar_pkg::PeriodW-1:0];

    case (seq_phase)
      ssi_aar_pkg::PH_CSWAIT: begin
        if (wait_ticks <= 1) seq_phase = ssi_aar_pkg::PH_CLKLOW;
        else wait_ticks = wait_ticks - 1;
      end
      ssi_aar_pkg::PH_CLKLOW: begin
        seq_phase  = ssi_aar_pkg::PH_CLKHIGH;
        wait_ticks = bit_delay;
      end
      ssi_aar_pkg::PH_CLKHIGH: begin
        if (wait_ticks <= 1) begin
          // sample on the last tick of the clock-high hold, msb first
          shift_reg = {shift_reg[ANGLE_BITS-2:0], data_bit};
          if (bits_to_go == '0) begin
            seq_phase = ssi_aar_pkg::PH_DONE;
          end else begin
            bits_to_go = bits_to_go - 1;
            seq_phase  = ssi_aar_pkg::PH_CLKLOW;
          end
        end else begin
          wait_ticks = wait_ticks - 1;
        end
      end
      ssi_aar_pkg::PH_DONE: begin
        held_angle = int'(shift_reg) - HALF_RANGE;
        done_now   = 1'b1;
        seq_phase  = ssi_aar_pkg::PH_IDLE;
      end
      default: begin
        // a period start during a read is simply lost
        seq_phase = ssi_aar_pkg::PH_IDLE;
        if (start_now) begin
          seq_phase  = ssi_aar_pkg::PH_CSWAIT;
          wait_ticks = bit_delay;
          bits_to_go = ssi_aar_pkg::BitsW'(ANGLE_BITS - 1);
          shift_reg  = '0;
        end
      end
    endcase

    // offset correction with a single wrap
    adj = held_angle - int'(zero_offset);
    if (adj < -HALF_RANGE) adj = adj + FULL_RANGE;
    if (adj > HALF_RANGE) adj = adj - FULL_RANGE;
    raw_sum = held_angle + HALF_RANGE;

    r.cs    = (seq_phase == ssi_aar_pkg::PH_IDLE);
    r.sclk  = (seq_phase != ssi_aar_pkg::PH_CLKLOW);
    r.valid = done_now;
    r.angle = adj[ANGLE_BITS:0];
    r.raw   = raw_sum[ANGLE_BITS-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // tick driver: predicts each accepted tick, then waits a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    logic                             next_valid;
    logic [ssi_aar_pkg::InTdataW-1:0] next_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      feed_wait     <= 0;
    end else begin
      next_valid = s_axis_tvalid;
      next_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        reading_q.push_back(advance_tick(s_axis_tdata[0]));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (feed_wait != 0) begin
          feed_wait <= feed_wait - 1;
        end else if (tick_q.size() != 0) begin
          next_data  = tick_q.pop_front();
          next_valid = 1'b1;
          feed_wait  <= $urandom_range(0, feed_gap_max);
        end
      end
      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_data;
    end
  end

  // result monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t    want;
    reading_t    got;
    int unsigned wait_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else begin
      wait_n = sink_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(reading_t)-1:0];
        if (reading_q.size() == 0) begin
          note_mismatch("unexpected result", '0, m_axis_tdata);
        end else begin
          want = reading_q.pop_front();
          if (got.cs !== want.cs) note_mismatch("sel_n", want.cs, got.cs);
          if (got.sclk !== want.sclk) note_mismatch("serial_clock", want.sclk, got.sclk);
          if (got.valid !== want.valid) note_mismatch("angle_valid", want.valid, got.valid);
          if (got.angle !== want.angle) note_mismatch("angle", want.angle, got.angle);
          if (got.raw !== want.raw) note_mismatch("raw_count", want.raw, got.raw);
          if (m_axis_tdata[OUT_W-1:$bits(reading_t)] !== '0) begin
            note_mismatch("tdata padding", '0, m_axis_tdata);
          end
        end
        wait_n = $urandom_range(0, sink_gap_max);
      end
      if (wait_n != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait     <= wait_n - 1;
      end else begin
        m_axis_tready <= 1'b1;
        sink_wait     <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ssi_absolute_angle_reader");
      $finish;
    end
  end

  // register write, mirrored at once since nothing is in flight
  task automatic write_reg(input ssi_aar_pkg::cfg_idx_e idx,
                           input logic [ssi_aar_pkg::CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      ssi_aar_pkg::CFG_OFFSET: zero_offset = value[ssi_aar_pkg::OffsetW-1:0];
      ssi_aar_pkg::CFG_DELAY:  bit_delay   = value[ssi_aar_pkg::DelayW-1:0];
      ssi_aar_pkg::CFG_PERIOD: poll_period = value[ssi_aar_pkg::PeriodW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_ticks(input int unsigned n, input int line_mode);
    logic line;
    for (int unsigned i = 0; i < n; i++) begin
      case (line_mode)
        LINE_ONES:  line = 1'b1;
        LINE_ZEROS: line = 1'b0;
        default:    line = 1'($urandom_range(0, 1));
      endcase
      tick_q.push_back({{(ssi_aar_pkg::InTdataW-1){1'b0}}, line});
      ticks_queued++;
    end
  endtask

  // wait until every tick is sent and every reading has come back
  task automatic drain();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || reading_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int                              pick;
    int unsigned                     xfer;
    int unsigned                     guard;
    logic [ssi_aar_pkg::OffsetW-1:0] off;
    logic [ssi_aar_pkg::DelayW-1:0]  dly;
    logic [ssi_aar_pkg::PeriodW-1:0] per;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero delay and period, most negative offset: angle sits at +2048 before
    // the first read, starts collide with the read, all ones wraps to -1
    feed_gap_max = 0;
    sink_gap_max = 0;
    write_reg(ssi_aar_pkg::CFG_OFFSET, ssi_aar_pkg::CfgW'(12'h800));
    write_reg(ssi_aar_pkg::CFG_DELAY, '0);
    write_reg(ssi_aar_pkg::CFG_PERIOD, '0);
    queue_ticks(28, LINE_ONES);
    drain();

    // most positive offset with an all-zero reading wraps upward
    feed_gap_max = 16;
    sink_gap_max = 16;
    write_reg(ssi_aar_pkg::CFG_OFFSET, ssi_aar_pkg::CfgW'(12'h7ff));
    queue_ticks(28, LINE_ZEROS);
    drain();

    // park the sequencer idle away from a period start, then widest settings
    write_reg(ssi_aar_pkg::CFG_DELAY, ssi_aar_pkg::CfgW'(1));
    write_reg(ssi_aar_pkg::CFG_PERIOD, ssi_aar_pkg::CfgW'(40));
    guard = 0;
    while ((seq_phase != ssi_aar_pkg::PH_IDLE || tick_in_period == '0) && guard < 200) begin
      queue_ticks(1, LINE_RANDOM);
      drain();
      guard++;
    end
    write_reg(ssi_aar_pkg::CFG_DELAY, ssi_aar_pkg::CfgW'(16'hffff));
    write_reg(ssi_aar_pkg::CFG_PERIOD, ssi_aar_pkg::CfgW'(24'hffffff));
    queue_ticks(20, LINE_RANDOM);
    drain();

    // random phases: short delays and periods so reads complete often
    while (ticks_queued < TICK_TARGET) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0:       off = 12'h800;
        1:       off = 12'h7ff;
        2:       off = '0;
        default: off = 12'($urandom());
      endcase
      pick = $urandom_range(0, 7);
      case (pick)
        0:       dly = '0;
        1:       dly = ssi_aar_pkg::DelayW'($urandom_range(5, 12));
        default: dly = ssi_aar_pkg::DelayW'($urandom_range(1, 3));
      endcase
      xfer = 3 + 13 * ((dly == '0) ? 1 : dly);
      pick = $urandom_range(0, 7);
      case (pick)
        0:       per = '0;
        1:       per = ssi_aar_pkg::PeriodW'(1);
        2:       per = ssi_aar_pkg::PeriodW'($urandom_range(2, xfer));
        default: per = ssi_aar_pkg::PeriodW'($urandom_range(xfer + 2, 3 * xfer));
      endcase
      feed_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      pick = $urandom_range(0, 2);
      case (pick)
        0: begin
          write_reg(ssi_aar_pkg::CFG_PERIOD, ssi_aar_pkg::CfgW'(per));
          write_reg(ssi_aar_pkg::CFG_DELAY, ssi_aar_pkg::CfgW'(dly));
          write_reg(ssi_aar_pkg::CFG_OFFSET, ssi_aar_pkg::CfgW'(off));
        end
        default: begin
          write_reg(ssi_aar_pkg::CFG_OFFSET, ssi_aar_pkg::CfgW'(off));
          write_reg(ssi_aar_pkg::CFG_DELAY, ssi_aar_pkg::CfgW'(dly));
          write_reg(ssi_aar_pkg::CFG_PERIOD, ssi_aar_pkg::CfgW'(per));
        end
      endcase
      pick = $urandom_range(0, 19);
      queue_ticks($urandom_range(40, 140),
                  (pick < 3) ? LINE_ONES : (pick < 6) ? LINE_ZEROS : LINE_RANDOM);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS ssi_absolute_angle_reader");
    end else begin
      $display("FAIL ssi_absolute_angle_reader");
    end
    $finish;
  end

endmodule
